### hdl/knps_pkg.sv
// Shared types and constants for the k-nearest point selector.
// Item structs, command codes, register indexes and width helpers.
// No dependencies.
package knps_pkg;

  localparam int ID_W       = 16;
  localparam int COORD_W    = 16;
  localparam int DIST_OUT_W = 34;
  localparam int RANK_W     = 4;
  localparam int CMD_W      = 2;
  localparam int CFG_W      = 16;
  localparam int KEEP_W     = 5;
  localparam int REG_IDX_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_QUERY_X    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_Y    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_Z    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT = 2'd3;

  localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = 5'd4;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [ID_W-1:0]           point_id;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]     rank;
    logic [ID_W-1:0]       result_id;
    logic [DIST_OUT_W-1:0] distance_sq;
    logic                  found;
    logic                  last;
  } out_item_t;

  // Width of one per-axis distance magnitude
  function automatic int mag_width(input int coord_bits);
    return ((coord_bits > COORD_W) ? coord_bits : COORD_W) + 1;
  endfunction

  // Width of an exact squared distance (sum of three squares)
  function automatic int dist_width(input int coord_bits);
    return 2 * mag_width(coord_bits) + 2;
  endfunction

endpackage

### hdl/knps_front.sv
// Front end of the k-nearest point selector: accepts items, drops unknown
// commands and computes the squared distance in a three-stage pipeline.
// Depends on knps_pkg.
module knps_front import knps_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int QDEPTH     = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  in_item_t                         in_item_i,
  output logic                             in_ready_o,
  input  logic signed [COORD_W-1:0]        query_x_i,
  input  logic signed [COORD_W-1:0]        query_y_i,
  input  logic signed [COORD_W-1:0]        query_z_i,
  input  logic [$clog2(QDEPTH+1)-1:0]      q_count_i,
  output logic                             push_o,
  output logic [CMD_W-1:0]                 push_cmd_o,
  output logic [ID_W-1:0]                  push_id_o,
  output logic [dist_width(COORD_BITS)-1:0] push_dist_o
);

  localparam int MW  = mag_width(COORD_BITS);
  localparam int DFW = MW + 1;
  localparam int SQW = 2 * MW;
  localparam int DW  = dist_width(COORD_BITS);
  localparam int RAWW = 24;
  localparam int CRW = $clog2(QDEPTH + 4);

  // Absolute difference of one axis, coordinate taken as COORD_BITS wide
  function automatic logic [MW-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                             input logic signed [COORD_W-1:0] q);
    logic [RAWW-1:0]        raw;
    logic signed [MW-1:0]   pe;
    logic signed [DFW-1:0]  d;
    raw = RAWW'(p);
    pe  = MW'(signed'(raw[COORD_BITS-1:0]));
    d   = DFW'(pe) - DFW'(q);
    return d[DFW-1] ? MW'(-d) : MW'(d);
  endfunction

  logic                 acc;
  logic [CRW-1:0]       occupancy;

  logic                 s1_v_q, s2_v_q, s3_v_q;
  logic [CMD_W-1:0]     s1_cmd_q, s2_cmd_q, s3_cmd_q;
  logic [ID_W-1:0]      s1_id_q, s2_id_q, s3_id_q;
  logic [MW-1:0]        s1_mx_q, s1_my_q, s1_mz_q;
  logic [SQW-1:0]       s2_sx_q, s2_sy_q, s2_sz_q;
  logic [DW-1:0]        s3_dist_q;

  // Reserve a queue slot for every item in flight
  assign occupancy = CRW'(q_count_i) + CRW'(s1_v_q) + CRW'(s2_v_q) + CRW'(s3_v_q);
  assign in_ready_o = occupancy < CRW'(QDEPTH);
  assign acc = in_valid_i && in_ready_o;

  // Advance stage valids; drop commands without meaning
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc && (in_item_i.command inside {CMD_CLEAR, CMD_OFFER, CMD_READ});
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Distance datapath: differences, squares, sum
  always_ff @(posedge clk_i) begin
    s1_cmd_q <= in_item_i.command;
    s1_id_q  <= in_item_i.point_id;
    s1_mx_q  <= abs_diff(in_item_i.point_x, query_x_i);
    s1_my_q  <= abs_diff(in_item_i.point_y, query_y_i);
    s1_mz_q  <= abs_diff(in_item_i.point_z, query_z_i);

    s2_cmd_q <= s1_cmd_q;
    s2_id_q  <= s1_id_q;
    s2_sx_q  <= s1_mx_q * s1_mx_q;
    s2_sy_q  <= s1_my_q * s1_my_q;
    s2_sz_q  <= s1_mz_q * s1_mz_q;

    s3_cmd_q  <= s2_cmd_q;
    s3_id_q   <= s2_id_q;
    s3_dist_q <= DW'(s2_sx_q) + DW'(s2_sy_q) + DW'(s2_sz_q);
  end

  assign push_o      = s3_v_q;
  assign push_cmd_o  = s3_cmd_q;
  assign push_id_o   = s3_id_q;
  assign push_dist_o = s3_dist_q;

endmodule

### hdl/knps_fifo.sv
// Short queue between the front and back of the k-nearest point selector.
// Generic width and depth; no dependencies beyond knps_pkg.
module knps_fifo import knps_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    count_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  // Move pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign count_o = count_q;

endmodule

### hdl/knps_back.sv
// Back end of the k-nearest point selector: holds the sorted list, runs
// clear, offer and readout, and drives the output register.
// Depends on knps_pkg.
module knps_back import knps_pkg::*; #(
  parameter int CAPACITY = 4,
  parameter int DW       = 36
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  logic [CMD_W-1:0]  head_cmd_i,
  input  logic [ID_W-1:0]   head_id_i,
  input  logic [DW-1:0]     head_dist_i,
  output logic              pop_o,
  input  logic [KEEP_W-1:0] keep_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [ID_W-1:0] ids_q   [CAPACITY];
  logic [DW-1:0]   dists_q [CAPACITY];
  logic [CNTW-1:0] total_q, total_d;
  logic            reading_q, reading_d;
  logic [IDXW-1:0] rd_q, rd_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic [CNTW-1:0] lim, lim_m1, n, m;
  logic            room, do_ins;
  logic [DW-1:0]   far_dist;
  logic            out_free, emit, offer;
  logic [IDXW-1:0] rd_idx;
  out_item_t       entry, empty_item;
  logic            entry_last;

  logic [CAPACITY-1:0] bigger, prev_bigger, take_new, take_prev;
  logic [ID_W-1:0]     prev_id   [CAPACITY];
  logic [DW-1:0]       prev_dist [CAPACITY];

  // Effective limit: keep count clamped to 1..CAPACITY
  always_comb begin
    if (keep_count_i == '0) begin
      lim = CNTW'(1);
    end else if (keep_count_i > KEEP_W'(CAPACITY)) begin
      lim = CNTW'(CAPACITY);
    end else begin
      lim = CNTW'(keep_count_i);
    end
  end

  assign lim_m1   = lim - 1'b1;
  assign room     = total_q < lim;
  assign n        = room ? total_q : lim;
  assign m        = room ? n : lim_m1;
  assign far_dist = dists_q[lim_m1[IDXW-1:0]];
  assign do_ins   = room || (head_dist_i < far_dist);

  // Per-slot compare and shift decision
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    logic in_list, at_or_below, keep_slot;
    assign in_list     = CNTW'(g) < m;
    assign at_or_below = CNTW'(g) <= m;
    assign bigger[g]   = in_list && (dists_q[g] > head_dist_i);
    assign keep_slot   = in_list && !bigger[g];
    if (g == 0) begin : g_first
      assign prev_bigger[g] = 1'b0;
      assign prev_id[g]     = '0;
      assign prev_dist[g]   = '0;
    end else begin : g_rest
      assign prev_bigger[g] = bigger[g-1];
      assign prev_id[g]     = ids_q[g-1];
      assign prev_dist[g]   = dists_q[g-1];
    end
    assign take_new[g]  = at_or_below && !keep_slot && !prev_bigger[g];
    assign take_prev[g] = at_or_below && !keep_slot && prev_bigger[g];
  end

  // Readout entry at the current rank
  assign rd_idx     = reading_q ? rd_q : '0;
  assign entry_last = (CNTW'(rd_idx) + CNTW'(1)) == n;
  always_comb begin
    entry.rank        = RANK_W'(rd_idx);
    entry.result_id   = ids_q[rd_idx];
    entry.distance_sq = DIST_OUT_W'(dists_q[rd_idx]);
    entry.found       = 1'b1;
    entry.last        = entry_last;
    empty_item        = '0;
    empty_item.last   = 1'b1;
  end

  // Sequence commands from the queue head
  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    emit        = 1'b0;
    offer       = 1'b0;
    pop_o       = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    total_d     = total_q;
    reading_d   = reading_q;
    rd_d        = rd_q;

    if (reading_q) begin
      if (out_free) begin
        emit  = 1'b1;
        out_d = entry;
        if (entry_last) begin
          reading_d = 1'b0;
        end else begin
          rd_d = IDXW'(rd_q + 1'b1);
        end
      end
    end else if (head_valid_i) begin
      case (head_cmd_i)
        CMD_CLEAR: begin
          pop_o   = 1'b1;
          total_d = '0;
        end
        CMD_OFFER: begin
          pop_o   = 1'b1;
          offer   = 1'b1;
          total_d = room ? CNTW'(n + 1'b1) : lim;
        end
        CMD_READ: begin
          if (out_free) begin
            pop_o = 1'b1;
            emit  = 1'b1;
            if (n == '0) begin
              out_d = empty_item;
            end else begin
              out_d = entry;
              if (!entry_last) begin
                reading_d = 1'b1;
                rd_d      = IDXW'(1);
              end
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end

    // Load or drain the output register
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      reading_q   <= 1'b0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      reading_q   <= reading_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Insert the offered point and shift farther entries down
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (offer && do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (take_new[i]) begin
          ids_q[i]   <= head_id_i;
          dists_q[i] <= head_dist_i;
        end else if (take_prev[i]) begin
          ids_q[i]   <= prev_id[i];
          dists_q[i] <= prev_dist[i];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### hdl/k_nearest_point_selector_core.sv
// Streaming k-nearest point selector: keeps the CAPACITY (or keep_count)
// points closest to the query position, sorted by squared distance.
// Clear and offer commands are taken one per clock while no readout is in
// progress; a readout emits one result per kept point (one when the list is
// empty) from the single output register, one result per cycle while the
// output is ready. An offered point passes a three-stage distance pipeline
// (difference, square, sum) and an eight-entry queue before the list, where a
// parallel compare and shift inserts it, so a readout sees every earlier
// offer. Depends on knps_pkg, knps_front, knps_fifo and knps_back.
module k_nearest_point_selector_core import knps_pkg::*; #(
  parameter int CAPACITY   = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int DW     = dist_width(COORD_BITS);
  localparam int QDEPTH = 8;
  localparam int QW     = CMD_W + ID_W + DW;
  localparam int QCW    = $clog2(QDEPTH + 1);

  logic signed [COORD_W-1:0] query_x_q, query_y_q, query_z_q;
  logic [KEEP_W-1:0]         keep_count_q;

  logic             push, pop;
  logic [CMD_W-1:0] push_cmd, head_cmd;
  logic [ID_W-1:0]  push_id, head_id;
  logic [DW-1:0]    push_dist, head_dist;
  logic [QW-1:0]    head_data;
  logic [QCW-1:0]   q_count;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q    <= '0;
      query_y_q    <= '0;
      query_z_q    <= '0;
      keep_count_q <= KEEP_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUERY_X:    query_x_q    <= signed'(cfg_wdata_i);
        REG_QUERY_Y:    query_y_q    <= signed'(cfg_wdata_i);
        REG_QUERY_Z:    query_z_q    <= signed'(cfg_wdata_i);
        REG_KEEP_COUNT: keep_count_q <= cfg_wdata_i[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  knps_front #(
    .COORD_BITS(COORD_BITS),
    .QDEPTH    (QDEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .query_x_i  (query_x_q),
    .query_y_i  (query_y_q),
    .query_z_i  (query_z_q),
    .q_count_i  (q_count),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .push_id_o  (push_id),
    .push_dist_o(push_dist)
  );

  knps_fifo #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({push_cmd, push_id, push_dist}),
    .pop_i  (pop),
    .data_o (head_data),
    .count_o(q_count)
  );

  assign {head_cmd, head_id, head_dist} = head_data;

  knps_back #(
    .CAPACITY(CAPACITY),
    .DW      (DW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_count != '0),
    .head_cmd_i  (head_cmd),
    .head_id_i   (head_id),
    .head_dist_i (head_dist),
    .pop_o       (pop),
    .keep_count_i(keep_count_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### bench/tb_k_nearest_point_selector_core.sv
// Testbench for k_nearest_point_selector_core: predicts the sorted nearest list
// per item and checks every readout result in order. Needs knps_pkg and the core.
module tb_k_nearest_point_selector_core;
  import knps_pkg::*;

  localparam int CAP          = 4;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 32;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Predicted block state
  logic signed [COORD_W-1:0] query_x = '0, query_y = '0, query_z = '0;
  logic [KEEP_W-1:0] keep_cfg = KEEP_COUNT_RESET;
  logic [ID_W-1:0] kept_id [CAP] = '{default: '0};
  logic [DIST_OUT_W-1:0] kept_dist [CAP] = '{default: '0};
  int unsigned kept_n = 0;

  out_item_t due_ranked_points [$];
  in_item_t last_offer = '0;

  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int err_count = 0;
  int n_sent = 0, n_offers = 0, n_reads = 0, n_results = 0;

  k_nearest_point_selector_core #(
    .CAPACITY  (CAP),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned keep_limit();
    if (keep_cfg == 0) return 1;
    if (keep_cfg > CAP) return CAP;
    return 32'(keep_cfg);
  endfunction

  function automatic logic [DIST_OUT_W-1:0] squared_distance(in_item_t it);
    longint dx, dy, dz;
    logic [DIST_OUT_W-1:0] d;
    dx = longint'($signed(it.point_x)) - longint'(query_x);
    dy = longint'($signed(it.point_y)) - longint'(query_y);
    dz = longint'($signed(it.point_z)) - longint'(query_z);
    d = DIST_OUT_W'(dx * dx + dy * dy + dz * dz);
    return d;
  endfunction

  // Append one result to the list of results still due
  function automatic void add_due(out_item_t r);
    due_ranked_points.insert(due_ranked_points.size(), r);
  endfunction

  // Insert behind all entries of equal or smaller distance
  function automatic void insert_kept(int unsigned n, logic [ID_W-1:0] id,
                                      logic [DIST_OUT_W-1:0] d);
    int unsigned p;
    p = 0;
    while (p < n && kept_dist[p] <= d) p++;
    for (int unsigned i = n; i > p; i--) begin
      kept_id[i] = kept_id[i-1];
      kept_dist[i] = kept_dist[i-1];
    end
    kept_id[p] = id;
    kept_dist[p] = d;
  endfunction

  // Update the nearest list for one accepted item and queue its readout
  function automatic void update_nearest_list(in_item_t it);
    int unsigned lim, n;
    logic [DIST_OUT_W-1:0] d;
    out_item_t r;
    lim = keep_limit();
    n = (kept_n < lim) ? kept_n : lim;
    case (it.command)
      CMD_CLEAR: kept_n = 0;
      CMD_OFFER: begin
        d = squared_distance(it);
        if (n < lim) begin
          insert_kept(n, it.point_id, d);
          kept_n = n + 1;
        end else begin
          if (d < kept_dist[lim-1]) insert_kept(lim - 1, it.point_id, d);
          kept_n = lim;
        end
      end
      CMD_READ: begin
        if (n == 0) begin
          r = '0;
          r.last = 1'b1;
          add_due(r);
        end
        for (int unsigned k = 0; k < n; k++) begin
          r.rank = RANK_W'(k);
          r.result_id = kept_id[k];
          r.distance_sq = kept_dist[k];
          r.found = 1'b1;
          r.last = (k + 1 == n);
          add_due(r);
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- items

  function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                         logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                         logic [COORD_W-1:0] z);
    in_item_t it;
    it.command = cmd;
    it.point_id = id;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    return it;
  endfunction

  // Random payload; only the command matters for clear and readout
  function automatic in_item_t noise_item(logic [CMD_W-1:0] cmd);
    return make_item(cmd, ID_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom));
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(logic [COORD_W-1:0] q);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      1: return q + COORD_W'($urandom_range(0, 64)) - 16'd32;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Offer near the query, at extremes, at random, or at the last offered spot for ties
  function automatic in_item_t rand_offer();
    in_item_t it;
    it = noise_item(CMD_OFFER);
    if ($urandom_range(0, 4) != 0) begin
      it.point_x = rand_coord(query_x);
      it.point_y = rand_coord(query_y);
      it.point_z = rand_coord(query_z);
    end else begin
      it.point_x = last_offer.point_x;
      it.point_y = last_offer.point_y;
      it.point_z = last_offer.point_z;
    end
    last_offer = it;
    return it;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one item, hold it until taken, then predict its effect
  task automatic send_item(in_item_t it);
    while (in_gaps && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    update_nearest_list(it);
    n_sent++;
    if (it.command == CMD_OFFER) n_offers++;
    if (it.command == CMD_READ) n_reads++;
  endtask

  // Drop valid, wait for every due result, then let the offer pipeline drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_ranked_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_QUERY_X:    query_x = data;
      REG_QUERY_Y:    query_y = data;
      REG_QUERY_Z:    query_z = data;
      REG_KEEP_COUNT: keep_cfg = data[KEEP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z);
    write_cfg(REG_QUERY_X, x);
    write_cfg(REG_QUERY_Y, y);
    write_cfg(REG_QUERY_Z, z);
  endtask

  // ---------------------------------------------------------------- checker

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    n_results++;
    if (due_ranked_points.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual rank %0d id %0h dist %0h",
               $time, got.rank, got.result_id, got.distance_sq);
      err_count++;
      return;
    end
    want = due_ranked_points.pop_front();
    compare_field("rank", 64'(want.rank), 64'(got.rank));
    compare_field("result_id", 64'(want.result_id), 64'(got.result_id));
    compare_field("distance_sq", 64'(want.distance_sq), 64'(got.distance_sq));
    compare_field("found", 64'(want.found), 64'(got.found));
    compare_field("last", 64'(want.last), 64'(got.last));
  endtask

  // Check each taken result, then pick next ready: long hold, random gaps or steady
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_item);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(out_gaps && $urandom_range(0, 99) < 15);
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_empty_readout();
    send_item(noise_item(CMD_READ));
    send_item(noise_item(CMD_CLEAR));
    send_item(noise_item(CMD_READ));
  endtask

  // Largest possible distance against zero distance, keep count at reset value
  task automatic test_distance_extremes();
    wait_idle();
    write_query(16'h8000, 16'h8000, 16'h8000);
    send_item(make_item(CMD_OFFER, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(make_item(CMD_OFFER, 16'h0000, 16'h8000, 16'h8000, 16'h8000));
    send_item(noise_item(CMD_READ));
  endtask

  // Fill with a tie, then reject an equal-to-farthest point and take a closer one
  task automatic test_ties_and_replacement();
    wait_idle();
    write_query(16'd0, 16'd0, 16'd0);
    write_cfg(REG_KEEP_COUNT, 16'd4);
    send_item(noise_item(CMD_CLEAR));
    send_item(make_item(CMD_OFFER, 16'd1, 16'd3, 16'd4, 16'd0));
    send_item(make_item(CMD_OFFER, 16'd2, 16'd0, 16'd0, 16'd5));
    send_item(make_item(CMD_OFFER, 16'd3, 16'd1, 16'd0, 16'd0));
    send_item(make_item(CMD_OFFER, 16'd4, 16'd10, 16'd0, 16'd0));
    send_item(make_item(CMD_OFFER, 16'd5, 16'd0, 16'd10, 16'd0));
    send_item(make_item(CMD_OFFER, 16'd6, 16'd0, 16'd0, -16'sd5));
    send_item(noise_item(CMD_READ));
  endtask

  // Lower the limit under the kept count, offer, then raise it again
  task automatic test_keep_lowered();
    wait_idle();
    write_cfg(REG_KEEP_COUNT, 16'd2);
    send_item(noise_item(CMD_READ));
    send_item(make_item(CMD_OFFER, 16'd7, 16'd2, 16'd0, 16'd0));
    wait_idle();
    write_cfg(REG_KEEP_COUNT, 16'd4);
    send_item(noise_item(CMD_READ));
  endtask

  task automatic test_unknown_command();
    send_item(noise_item(CMD_UNUSED));
    send_item(noise_item(CMD_READ));
  endtask

  // Stall the output long enough that readouts back up into the input
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_item((i % 3 == 2) ? noise_item(CMD_READ) : rand_offer());
    end
  endtask

  task automatic run_random_phase(int unsigned n_items, logic [KEEP_W-1:0] keep,
                                  bit extreme_query);
    logic [CFG_W-1:0] wdata;
    int unsigned pick;
    wait_idle();
    if (extreme_query) write_query(16'h7FFF, 16'h7FFF, 16'h7FFF);
    else write_query(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    wdata = CFG_W'($urandom);
    wdata[KEEP_W-1:0] = keep;
    write_cfg(REG_KEEP_COUNT, wdata);
    send_item(noise_item(CMD_CLEAR));
    for (int unsigned i = 1; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (i == n_items - 1 || pick < 20) send_item(noise_item(CMD_READ));
      else if (pick < 24) send_item(noise_item(CMD_CLEAR));
      else if (pick < 28) send_item(noise_item(CMD_UNUSED));
      else send_item(rand_offer());
    end
  endtask

  // Sweep keep counts including zero and above capacity; one phase runs gap-free
  task automatic test_random_phases();
    run_random_phase(18, 5'd0, 1'b0);
    run_random_phase(18, 5'd31, 1'b1);
    run_random_phase(18, 5'd1, 1'b0);
    wait_idle();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    run_random_phase(36, 5'd16, 1'b0);
    wait_idle();
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    run_random_phase(18, 5'd2, 1'b0);
    run_random_phase(18, KEEP_W'($urandom_range(0, 31)), 1'b0);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_readout();
    test_distance_extremes();
    test_ties_and_replacement();
    test_keep_lowered();
    test_unknown_command();
    test_output_backpressure();
    test_random_phases();
    wait_idle();
    $display("Sent %0d items (%0d offers, %0d readouts) and checked %0d results,",
             n_sent, n_offers, n_reads, n_results);
    $display("over keep counts 0 to 31, extreme and random query positions.");
    if (err_count == 0 && due_ranked_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still due", due_ranked_points.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
hdl/knps_pkg.sv
hdl/knps_front.sv
hdl/knps_fifo.sv
hdl/knps_back.sv
hdl/k_nearest_point_selector_core.sv
bench/tb_k_nearest_point_selector_core.sv
